// ===== rtl/gbb_pkg.sv =====
package gbb_pkg;

  localparam int DEMAND_BITS = 4;
  localparam int DEMAND_W    = 4;
  localparam int SERIAL_W    = 64;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DEMAND_W-1:0] DEMAND_MASK =
    DEMAND_W'((64'd1 << DEMAND_BITS) - 64'd1);
  localparam logic [SERIAL_W-1:0] SERIAL_MAX = '1;

  typedef enum logic [2:0] {
    OP_REQUEST   = 3'd0,
    OP_COMPLETE  = 3'd1,
    OP_TAKE_OLD  = 3'd2,
    OP_TAKE_SER  = 3'd3,
    OP_RELEASE   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_INVALID  = 3'd1,
    STS_CAPACITY = 3'd2,
    STS_BLOCK    = 3'd3,
    STS_NONE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    BK_FREE       = 4'b0001,
    BK_COLLECTING = 4'b0010,
    BK_READY      = 4'b0100,
    BK_SENDING    = 4'b1000
  } bank_st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALID_MASK  = 1'b0,
    CFG_RETAIN_MASK = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [DEMAND_W-1:0] demand;
    logic [SERIAL_W-1:0] serial;
    logic [1:0]          bank;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                wake;
    logic [SERIAL_W-1:0] serial_out;
    logic [DEMAND_W-1:0] demand_out;
    logic [1:0]          bank_out;
    logic                open_valid;
    logic [SERIAL_W-1:0] open_serial;
    logic [DEMAND_W-1:0] open_demand;
    logic                busy_res;
  } out_item_t;

endpackage

// ===== rtl/gbb_step.sv =====
module gbb_step #(
  parameter int BANKS = 4
) (
  input  gbb_pkg::in_item_t                 item,
  input  logic [gbb_pkg::DEMAND_W-1:0]      vmask,
  input  logic [gbb_pkg::DEMAND_W-1:0]      rmask,
  input  gbb_pkg::bank_st_t                 st_i    [BANKS],
  input  logic [gbb_pkg::SERIAL_W-1:0]      ser_i   [BANKS],
  input  logic [gbb_pkg::DEMAND_W-1:0]      dem_i   [BANKS],
  input  logic [gbb_pkg::SERIAL_W-1:0]      next_ser_i,
  input  logic                              spent_i,
  input  logic [gbb_pkg::DEMAND_W-1:0]      defer_i,
  output gbb_pkg::bank_st_t                 st_o    [BANKS],
  output logic [gbb_pkg::SERIAL_W-1:0]      ser_o   [BANKS],
  output logic [gbb_pkg::DEMAND_W-1:0]      dem_o   [BANKS],
  output logic [gbb_pkg::SERIAL_W-1:0]      next_ser_o,
  output logic                              spent_o,
  output logic [gbb_pkg::DEMAND_W-1:0]      defer_o,
  output gbb_pkg::out_item_t                res_o
);

  localparam int IDX_W = (BANKS > 1) ? $clog2(BANKS) : 1;

  function automatic logic [IDX_W-1:0] lowest_idx(input logic [BANKS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = BANKS - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  logic [BANKS-1:0] coll_m, free_m, ready_m, old_m, tser_m, cmpl_m, rel_m, open_free_m;
  logic [IDX_W-1:0] coll_idx, pick_idx, cmpl_idx, open_idx, post_coll_idx;
  logic             serial_nz, dem_bad, rel_ok, open_en, take_en, post_coll;
  logic [gbb_pkg::DEMAND_W-1:0] open_dem;
  logic [BANKS-1:0] busy_m, post_coll_m;

  always_comb begin
    for (int i = 0; i < BANKS; i++) begin
      coll_m[i]  = (st_i[i] == gbb_pkg::BK_COLLECTING);
      free_m[i]  = (st_i[i] == gbb_pkg::BK_FREE);
      ready_m[i] = (st_i[i] == gbb_pkg::BK_READY);
    end
    serial_nz = (item.serial != '0);

    // oldest ready: beat every other ready bank, ties to the lower index
    for (int i = 0; i < BANKS; i++) begin
      old_m[i] = ready_m[i];
      for (int j = 0; j < BANKS; j++) begin
        if (j != i && ready_m[j]) begin
          if (j < i) old_m[i] = old_m[i] & (ser_i[i] < ser_i[j]);
          else       old_m[i] = old_m[i] & (ser_i[i] <= ser_i[j]);
        end
      end
      tser_m[i] = ready_m[i] && serial_nz && (ser_i[i] == item.serial);
      cmpl_m[i] = coll_m[i] && serial_nz && (ser_i[i] == item.serial);
      rel_m[i]  = (int'(item.bank) == i) && (st_i[i] == gbb_pkg::BK_SENDING) &&
                  (ser_i[i] == item.serial);
    end
    coll_idx = lowest_idx(coll_m);
    cmpl_idx = lowest_idx(cmpl_m);
    pick_idx = (item.op == gbb_pkg::OP_TAKE_OLD) ? lowest_idx(old_m) : lowest_idx(tser_m);

    dem_bad = (item.demand == '0) || ((item.demand & ~vmask) != '0) ||
              ((item.demand & ~gbb_pkg::DEMAND_MASK) != '0);
    rel_ok  = (item.op == gbb_pkg::OP_RELEASE) && serial_nz && (rel_m != '0);

    open_free_m = free_m | (rel_ok ? rel_m : '0);
    open_idx    = lowest_idx(open_free_m);
    open_en     = 1'b0;
    open_dem    = '0;
    take_en     = 1'b0;

    st_o       = st_i;
    ser_o      = ser_i;
    dem_o      = dem_i;
    next_ser_o = next_ser_i;
    spent_o    = spent_i;
    defer_o    = defer_i;

    res_o = '0;
    res_o.status = gbb_pkg::STS_OK;

    case (item.op)
      gbb_pkg::OP_REQUEST: begin
        if (dem_bad) begin
          res_o.status = gbb_pkg::STS_INVALID;
        end else if (coll_m != '0) begin
          dem_o[coll_idx]  = (dem_i[coll_idx] | item.demand) & gbb_pkg::DEMAND_MASK;
          res_o.serial_out = ser_i[coll_idx];
        end else if (spent_i) begin
          res_o.status = gbb_pkg::STS_CAPACITY;
        end else if (free_m != '0) begin
          open_en  = 1'b1;
          open_dem = item.demand;
        end else begin
          defer_o = (defer_i | (item.demand & rmask)) & gbb_pkg::DEMAND_MASK;
          res_o.status = gbb_pkg::STS_BLOCK;
        end
      end
      gbb_pkg::OP_COMPLETE: begin
        if (cmpl_m != '0) st_o[cmpl_idx] = gbb_pkg::BK_READY;
      end
      gbb_pkg::OP_TAKE_OLD, gbb_pkg::OP_TAKE_SER: begin
        if ((item.op == gbb_pkg::OP_TAKE_OLD && old_m != '0) ||
            (item.op == gbb_pkg::OP_TAKE_SER && tser_m != '0)) begin
          take_en = 1'b1;
        end else begin
          res_o.status = gbb_pkg::STS_NONE;
        end
      end
      gbb_pkg::OP_RELEASE: begin
        if (!rel_ok) begin
          res_o.status = gbb_pkg::STS_INVALID;
        end else if (defer_i != '0 && !spent_i && coll_m == '0) begin
          open_en  = 1'b1;
          open_dem = defer_i;
          defer_o  = '0;
        end
      end
      default: res_o.status = gbb_pkg::STS_INVALID;
    endcase

    if (take_en) begin
      st_o[pick_idx]   = gbb_pkg::BK_SENDING;
      res_o.serial_out = ser_i[pick_idx];
      res_o.demand_out = dem_i[pick_idx];
      res_o.bank_out   = 2'(pick_idx);
    end

    for (int i = 0; i < BANKS; i++) begin
      if (rel_ok && rel_m[i]) begin
        st_o[i]  = gbb_pkg::BK_FREE;
        ser_o[i] = '0;
        dem_o[i] = '0;
      end
    end

    if (open_en) begin
      st_o[open_idx]  = gbb_pkg::BK_COLLECTING;
      ser_o[open_idx] = next_ser_i;
      dem_o[open_idx] = open_dem & gbb_pkg::DEMAND_MASK;
      // the counter stops at the top value instead of wrapping
      if (next_ser_i == gbb_pkg::SERIAL_MAX) spent_o = 1'b1;
      else next_ser_o = next_ser_i + gbb_pkg::SERIAL_W'(1);
      res_o.wake       = 1'b1;
      res_o.serial_out = next_ser_i;
    end

    for (int i = 0; i < BANKS; i++) begin
      busy_m[i]      = (st_o[i] != gbb_pkg::BK_FREE);
      post_coll_m[i] = (st_o[i] == gbb_pkg::BK_COLLECTING);
    end
    post_coll     = (post_coll_m != '0);
    post_coll_idx = lowest_idx(post_coll_m);
    res_o.busy_res    = (busy_m != '0);
    res_o.open_valid  = post_coll;
    res_o.open_serial = post_coll ? ser_o[post_coll_idx] : '0;
    res_o.open_demand = post_coll ? dem_o[post_coll_idx] : '0;
  end

endmodule

// ===== rtl/generation_bank_broker_unit.sv =====
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   gbb_pkg::in_item_t   (op, demand, serial, bank)
// out_     output     out_valid / out_stall gbb_pkg::out_item_t  (status .. busy_res)
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ is not stalled; an accepted request is
// held in the input register; it feeds the bank update, which loads the result register.
// The bank update is combinational: every bank is compared in parallel.
// rst_n (synchronous) frees all banks, sets the next serial to one, clears deferred demand
// and restores both masks. A stalled result holds the input register, which then stalls in_.
module generation_bank_broker_unit #(
  parameter int BANKS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gbb_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gbb_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [gbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gbb_pkg::DEMAND_W-1:0]        cfg_wdata
);

  logic                          in_vld_r;
  gbb_pkg::in_item_t             in_item_r;
  logic                          out_vld_r;
  gbb_pkg::out_item_t            out_item_r;
  logic                          advance;

  gbb_pkg::bank_st_t             st_r     [BANKS];
  logic [gbb_pkg::SERIAL_W-1:0]  ser_r    [BANKS];
  logic [gbb_pkg::DEMAND_W-1:0]  dem_r    [BANKS];
  gbb_pkg::bank_st_t             st_nxt   [BANKS];
  logic [gbb_pkg::SERIAL_W-1:0]  ser_nxt  [BANKS];
  logic [gbb_pkg::DEMAND_W-1:0]  dem_nxt  [BANKS];
  logic [gbb_pkg::SERIAL_W-1:0]  next_ser_r, next_ser_nxt;
  logic                          spent_r, spent_nxt;
  logic [gbb_pkg::DEMAND_W-1:0]  defer_r, defer_nxt;
  logic [gbb_pkg::DEMAND_W-1:0]  vmask_r, rmask_r;
  gbb_pkg::out_item_t            res_nxt;

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  gbb_step #(
    .BANKS(BANKS)
  ) u_step (
    .item       (in_item_r),
    .vmask      (vmask_r),
    .rmask      (rmask_r),
    .st_i       (st_r),
    .ser_i      (ser_r),
    .dem_i      (dem_r),
    .next_ser_i (next_ser_r),
    .spent_i    (spent_r),
    .defer_i    (defer_r),
    .st_o       (st_nxt),
    .ser_o      (ser_nxt),
    .dem_o      (dem_nxt),
    .next_ser_o (next_ser_nxt),
    .spent_o    (spent_nxt),
    .defer_o    (defer_nxt),
    .res_o      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      next_ser_r <= gbb_pkg::SERIAL_W'(1);
      spent_r    <= 1'b0;
      defer_r    <= '0;
      vmask_r    <= gbb_pkg::DEMAND_W'(15);
      rmask_r    <= gbb_pkg::DEMAND_W'(1);
      for (int i = 0; i < BANKS; i++) begin
        st_r[i]  <= gbb_pkg::BK_FREE;
        ser_r[i] <= '0;
        dem_r[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        in_vld_r  <= in_valid;
        in_item_r <= in_data;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          out_item_r <= res_nxt;
          st_r       <= st_nxt;
          ser_r      <= ser_nxt;
          dem_r      <= dem_nxt;
          next_ser_r <= next_ser_nxt;
          spent_r    <= spent_nxt;
          defer_r    <= defer_nxt;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          gbb_pkg::CFG_VALID_MASK:  vmask_r <= cfg_wdata;
          gbb_pkg::CFG_RETAIN_MASK: rmask_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb_generation_bank_broker_unit.sv =====
`timescale 1ns / 100ps

module tb_generation_bank_broker_unit;

  localparam int NB   = 4;
  localparam int ST_W = $bits(gbb_pkg::bank_st_t);

  typedef struct packed {
    logic [NB-1:0][ST_W-1:0]              st;
    logic [NB-1:0][gbb_pkg::SERIAL_W-1:0] ser;
    logic [NB-1:0][gbb_pkg::DEMAND_W-1:0] dem;
    logic [gbb_pkg::SERIAL_W-1:0]         next_ser;
    logic                                 spent;
    logic [gbb_pkg::DEMAND_W-1:0]         deferred;
    logic [gbb_pkg::DEMAND_W-1:0]         vmask;
    logic [gbb_pkg::DEMAND_W-1:0]         rmask;
  } broker_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  gbb_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  gbb_pkg::out_item_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [gbb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gbb_pkg::DEMAND_W-1:0]  cfg_wdata = '0;

  broker_t            model;     // state seen by the result predictor
  broker_t            plan;      // state seen by the request generator
  gbb_pkg::in_item_t  pend_q[$];
  gbb_pkg::out_item_t exp_q[$];
  int        queued_cnt = 0;
  int        accept_cnt = 0;
  int        result_cnt = 0;
  int        errors = 0;
  int        idle_odds = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      long_hold = 1'b0;

  generation_bank_broker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_open(broker_t s);
    int i;
    for (i = 0; i < NB; i++)
      if (s.st[i] == gbb_pkg::BK_COLLECTING) return i;
    return -1;
  endfunction

  function automatic int pick_in(broker_t s, gbb_pkg::bank_st_t want);
    int hits[$];
    int i;
    for (i = 0; i < NB; i++)
      if (s.st[i] == want) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int open_free(inout broker_t s,
                                   input logic [gbb_pkg::DEMAND_W-1:0] d);
    int i;
    for (i = 0; i < NB; i++) begin
      if (s.st[i] == gbb_pkg::BK_FREE) begin
        s.ser[i] = s.next_ser;
        // the counter sticks at its top value
        if (s.next_ser == gbb_pkg::SERIAL_MAX) s.spent = 1'b1;
        else s.next_ser = s.next_ser + gbb_pkg::SERIAL_W'(1);
        s.dem[i] = d & gbb_pkg::DEMAND_MASK;
        s.st[i] = gbb_pkg::BK_COLLECTING;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic gbb_pkg::out_item_t broker_step(inout broker_t s,
                                                     input gbb_pkg::in_item_t it);
    gbb_pkg::out_item_t r;
    int pick;
    int i;
    r = '0;
    case (it.op)
      gbb_pkg::OP_REQUEST: begin
        if (it.demand == 0 || (it.demand & ~s.vmask) != 0 ||
            (it.demand & ~gbb_pkg::DEMAND_MASK) != 0) begin
          r.status = gbb_pkg::STS_INVALID;
        end else begin
          pick = find_open(s);
          if (pick >= 0) begin
            s.dem[pick] = (s.dem[pick] | it.demand) & gbb_pkg::DEMAND_MASK;
            r.serial_out = s.ser[pick];
          end else if (s.spent) begin
            r.status = gbb_pkg::STS_CAPACITY;
          end else begin
            pick = open_free(s, it.demand);
            if (pick >= 0) begin
              r.wake = 1'b1;
              r.serial_out = s.ser[pick];
            end else begin
              s.deferred = (s.deferred | (it.demand & s.rmask)) & gbb_pkg::DEMAND_MASK;
              r.status = gbb_pkg::STS_BLOCK;
            end
          end
        end
      end
      gbb_pkg::OP_COMPLETE: begin
        pick = -1;
        if (it.serial != 0)
          for (i = 0; i < NB; i++)
            if (pick < 0 && s.st[i] == gbb_pkg::BK_COLLECTING && s.ser[i] == it.serial)
              pick = i;
        if (pick >= 0) s.st[pick] = gbb_pkg::BK_READY;
      end
      gbb_pkg::OP_TAKE_OLD, gbb_pkg::OP_TAKE_SER: begin
        pick = -1;
        for (i = 0; i < NB; i++) begin
          if (s.st[i] == gbb_pkg::BK_READY) begin
            if (it.op == gbb_pkg::OP_TAKE_OLD) begin
              // strict less-than keeps the lowest bank on a tie
              if (pick < 0 || s.ser[i] < s.ser[pick]) pick = i;
            end else if (pick < 0 && it.serial != 0 && s.ser[i] == it.serial) begin
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          r.status = gbb_pkg::STS_NONE;
        end else begin
          s.st[pick] = gbb_pkg::BK_SENDING;
          r.serial_out = s.ser[pick];
          r.demand_out = s.dem[pick];
          r.bank_out = 2'(pick);
        end
      end
      gbb_pkg::OP_RELEASE: begin
        if (it.serial == 0 || int'(it.bank) >= NB || s.st[it.bank] != gbb_pkg::BK_SENDING ||
            s.ser[it.bank] != it.serial) begin
          r.status = gbb_pkg::STS_INVALID;
        end else begin
          s.st[it.bank] = gbb_pkg::BK_FREE;
          s.ser[it.bank] = '0;
          s.dem[it.bank] = '0;
          if (s.deferred != 0 && !s.spent && find_open(s) < 0) begin
            pick = open_free(s, s.deferred);
            if (pick >= 0) begin
              s.deferred = '0;
              r.wake = 1'b1;
              r.serial_out = s.ser[pick];
            end
          end
        end
      end
      default: r.status = gbb_pkg::STS_INVALID;
    endcase
    for (i = 0; i < NB; i++)
      if (s.st[i] != gbb_pkg::BK_FREE) r.busy_res = 1'b1;
    pick = find_open(s);
    if (pick >= 0) begin
      r.open_valid = 1'b1;
      r.open_serial = s.ser[pick];
      r.open_demand = s.dem[pick];
    end
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    logic took;
    logic nv;
    took = 1'b0;
    nv = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        exp_q.push_back(broker_step(model, in_data));
        accept_cnt++;
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pend_q.size() != 0 && $urandom_range(0, 99) < idle_odds) begin
          tx_gap = $urandom_range(0, 10);
        end else if (pend_q.size() != 0) begin
          in_data <= pend_q.pop_front();
          nv = 1'b1;
        end
        in_valid <= nv;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    gbb_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d serial %h", out_data.status,
                     out_data.serial_out);
        end else begin
          want = exp_q.pop_front();
          if (out_data.status !== want.status || out_data.wake !== want.wake ||
              out_data.serial_out !== want.serial_out ||
              out_data.demand_out !== want.demand_out ||
              out_data.bank_out !== want.bank_out ||
              out_data.open_valid !== want.open_valid ||
              out_data.open_serial !== want.open_serial ||
              out_data.open_demand !== want.open_demand ||
              out_data.busy_res !== want.busy_res) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d", result_cnt);
              $display("  exp: st %0d wk %0d ser %h dem %h bk %0d open %0d %h %h busy %0d",
                       want.status, want.wake, want.serial_out, want.demand_out,
                       want.bank_out, want.open_valid, want.open_serial,
                       want.open_demand, want.busy_res);
              $display("  got: st %0d wk %0d ser %h dem %h bk %0d open %0d %h %h busy %0d",
                       out_data.status, out_data.wake, out_data.serial_out,
                       out_data.demand_out, out_data.bank_out, out_data.open_valid,
                       out_data.open_serial, out_data.open_demand, out_data.busy_res);
            end
          end
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_odds) begin
        rx_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    @(posedge clk);
    while (!rst_n || accept_cnt < 60) @(posedge clk);
    long_hold <= 1'b1;
    repeat (250) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_item(gbb_pkg::in_item_t it);
    pend_q.push_back(it);
    void'(broker_step(plan, it));
    queued_cnt++;
  endtask

  task automatic push_fields(logic [2:0] op, logic [gbb_pkg::DEMAND_W-1:0] d,
                             logic [gbb_pkg::SERIAL_W-1:0] ser, logic [1:0] bk);
    gbb_pkg::in_item_t it;
    it.op = op;
    it.demand = d;
    it.serial = ser;
    it.bank = bk;
    push_item(it);
  endtask

  task automatic push_random(int n);
    gbb_pkg::in_item_t it;
    int k;
    int j;
    int r;
    for (k = 0; k < n; k++) begin
      it.op = gbb_pkg::OP_REQUEST;
      it.demand = gbb_pkg::DEMAND_W'($urandom);
      it.serial = {$urandom, $urandom};
      it.bank = 2'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        it.demand = gbb_pkg::DEMAND_W'($urandom) & plan.vmask;
        if (it.demand == 0) it.demand = plan.vmask;
      end else if (r < 44) begin
        it.op = gbb_pkg::OP_COMPLETE;
        j = find_open(plan);
        if (j >= 0) it.serial = plan.ser[j];
      end else if (r < 54) begin
        it.op = gbb_pkg::OP_TAKE_OLD;
      end else if (r < 64) begin
        it.op = gbb_pkg::OP_TAKE_SER;
        j = pick_in(plan, gbb_pkg::BK_READY);
        if (j >= 0) it.serial = plan.ser[j];
      end else if (r < 80) begin
        it.op = gbb_pkg::OP_RELEASE;
        j = pick_in(plan, gbb_pkg::BK_SENDING);
        if (j >= 0) begin
          it.bank = 2'(j);
          it.serial = plan.ser[j];
        end
      end else begin
        // noise: any op, serials at zero or close to live ones
        it.op = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 2))
          0: it.serial = '0;
          1: it.serial = plan.next_ser - gbb_pkg::SERIAL_W'($urandom_range(0, 4));
          default: ;
        endcase
      end
      push_item(it);
    end
  endtask

  task automatic settle();
    while (result_cnt < queued_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(gbb_pkg::cfg_idx_t idx, logic [gbb_pkg::DEMAND_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == gbb_pkg::CFG_VALID_MASK) begin
      model.vmask = v;
      plan.vmask = v;
    end else begin
      model.rmask = v;
      plan.rmask = v;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    logic [gbb_pkg::DEMAND_W-1:0] vm;
    logic [gbb_pkg::DEMAND_W-1:0] rm;
    model = '0;
    for (int b = 0; b < NB; b++) model.st[b] = gbb_pkg::BK_FREE;
    model.next_ser = gbb_pkg::SERIAL_W'(1);
    model.vmask = 4'hF;
    model.rmask = 4'h1;
    plan = model;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_odds = 12;

    push_fields(gbb_pkg::OP_REQUEST, 4'h0, 64'd0, 2'd0);    // empty demand
    push_fields(3'd5, 4'h1, 64'd1, 2'd1);                    // unknown ops
    push_fields(3'd7, 4'hF, '1, 2'd3);
    push_fields(gbb_pkg::OP_REQUEST, 4'hF, 64'd0, 2'd0);    // opens bank 0
    push_fields(gbb_pkg::OP_REQUEST, 4'h1, 64'd0, 2'd0);    // joins it
    push_fields(gbb_pkg::OP_COMPLETE, 4'h0, 64'd0, 2'd0);   // zero serial, ignored
    push_fields(gbb_pkg::OP_COMPLETE, 4'h0, 64'd1, 2'd0);
    push_fields(gbb_pkg::OP_TAKE_SER, 4'h0, 64'd0, 2'd0);   // zero serial, nothing taken
    push_fields(gbb_pkg::OP_TAKE_OLD, 4'h0, 64'd0, 2'd0);
    push_fields(gbb_pkg::OP_TAKE_OLD, 4'h0, 64'd0, 2'd0);   // nothing ready
    push_fields(gbb_pkg::OP_RELEASE, 4'h0, 64'd1, 2'd1);    // wrong bank
    push_fields(gbb_pkg::OP_RELEASE, 4'h0, 64'd0, 2'd0);    // zero serial
    push_fields(gbb_pkg::OP_REQUEST, 4'h2, 64'd0, 2'd0);
    push_fields(gbb_pkg::OP_COMPLETE, 4'h0, 64'd2, 2'd0);
    push_fields(gbb_pkg::OP_REQUEST, 4'h4, 64'd0, 2'd0);
    push_fields(gbb_pkg::OP_COMPLETE, 4'h0, 64'd3, 2'd0);
    push_fields(gbb_pkg::OP_REQUEST, 4'h8, 64'd0, 2'd0);
    push_fields(gbb_pkg::OP_COMPLETE, 4'h0, 64'd4, 2'd0);
    push_fields(gbb_pkg::OP_REQUEST, 4'h1, 64'd0, 2'd0);    // no free bank, defer
    push_fields(gbb_pkg::OP_REQUEST, 4'h3, 64'd0, 2'd0);
    push_fields(gbb_pkg::OP_TAKE_SER, 4'h0, 64'd3, 2'd0);
    push_fields(gbb_pkg::OP_TAKE_OLD, 4'h0, 64'd0, 2'd0);   // oldest of the rest
    push_fields(gbb_pkg::OP_RELEASE, 4'h0, 64'd1, 2'd0);    // opens the deferred demand
    push_fields(gbb_pkg::OP_RELEASE, 4'h0, 64'd3, 2'd2);
    push_fields(gbb_pkg::OP_REQUEST, 4'h8, '1, 2'd3);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin vm = 4'hF; rm = 4'hF; idle_odds = 12; end
        1: begin vm = 4'h1; rm = 4'h0; idle_odds = 25; end
        2: begin
          vm = gbb_pkg::DEMAND_W'($urandom_range(1, 15));
          rm = gbb_pkg::DEMAND_W'($urandom_range(0, 15));
          idle_odds = 0;
        end
        3: begin vm = 4'hF; rm = 4'h0; idle_odds = 12; end
        4: begin vm = 4'h1; rm = 4'hF; idle_odds = 30; end
        default: begin
          vm = gbb_pkg::DEMAND_W'($urandom_range(1, 15));
          rm = gbb_pkg::DEMAND_W'($urandom_range(0, 15));
          idle_odds = 0;
        end
      endcase
      write_reg(gbb_pkg::CFG_VALID_MASK, vm);
      write_reg(gbb_pkg::CFG_RETAIN_MASK, rm);
      push_random(140);
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gbb_pkg.sv
rtl/gbb_step.sv
rtl/generation_bank_broker_unit.sv
test/tb_generation_bank_broker_unit.sv
